// File: rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the three-class priority queue: transaction
// payloads, operation and status codes, cell commands and control states.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int ID_W         = 16;
    localparam int CLS_W        = 2;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_SERVE = 2'd1,
        OP_LIST  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_ENTRY    = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_ENQUEUED = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    // class code that is rejected
    localparam logic [CLS_W-1:0] CLS_INVALID = 2'd3;

    // input transaction payload
    typedef struct packed {
        logic [1:0]       operation;
        logic [ID_W-1:0]  entry_id;
        logic [CLS_W-1:0] entry_class;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [2:0]       status;
        logic [ID_W-1:0]  out_id;
        logic [CLS_W-1:0] out_class;
        logic             last;
    } t_out_item;

    // one stored entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
    } t_entry;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        t_entry    new_entry;
    } t_cell_ctl;

    // control states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

endpackage

// File: rtl/tcpq_cell.sv
// ----------------------------------------------------------------------------
// tcpq_cell
// One slot of the ordered store. Holds an entry and, on each command, keeps
// it or takes the entry of a neighbor, the new entry or the head entry.
// ----------------------------------------------------------------------------
module tcpq_cell #(
    parameter int IDX   = 0,
    parameter int OCC_W = 6
) (
    input  logic               i_clk,
    input  tcpq_pkg::t_cell_ctl i_ctl,
    input  logic [OCC_W-1:0]   i_occ,
    input  tcpq_pkg::t_entry   i_prev,
    input  logic               i_prev_after,
    input  tcpq_pkg::t_entry   i_next,
    input  tcpq_pkg::t_entry   i_head,
    output tcpq_pkg::t_entry   o_entry,
    output logic               o_after
);
    import tcpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   occupied;
    logic   is_tail;

    // slot position relative to the fill level
    assign occupied = OCC_W'(IDX) < i_occ;
    assign is_tail  = OCC_W'(IDX + 1) == i_occ;

    // new entry belongs behind this one
    assign o_after = occupied && (r_entry.cls <= i_ctl.new_entry.cls);
    assign o_entry = r_entry;

    // next entry selection
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CELL_INSERT: begin
                if (o_after) begin
                    n_entry = r_entry;
                end else if (i_prev_after) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_prev;
                end
            end
            CELL_SHIFT: begin
                n_entry = i_next;
            end
            CELL_ROTATE: begin
                n_entry = is_tail ? i_head : i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // entry register
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/three_class_priority_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Strict priority queue with three classes, first-in first-out within a
// class, kept in service order in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-------------------------
//  input   | i_in_valid   | o_in_ready   | i_in_item  (t_in_item)
//  output  | o_out_valid  | i_out_ready  | o_out_item (t_out_item)
//
// Enqueue and serve give one result each; the chain inserts or shifts at the accepting edge.
// List gives one result per waiting entry, rotating the cells to restore the store.
// Input waits while a list runs or the output register is full and stalled;
// a stalled output also holds the list walk in place.
// Reset clears the fill count, list counter, control state and the output valid.
// ----------------------------------------------------------------------------
module three_class_priority_queue #(
    parameter int CAPACITY = tcpq_pkg::DEF_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcpq_pkg::t_out_item o_out_item
);
    import tcpq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_state           r_state;
    t_state           n_state;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic [OCC_W-1:0] r_cnt;
    logic [OCC_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             load_out;
    logic             out_free;
    logic             in_accept;
    logic             list_done;
    logic             full;
    logic             empty;
    t_op              op;
    t_cell_ctl        cell_ctl;
    t_entry           cell_q     [CAPACITY];
    logic             cell_after [CAPACITY];

    assign op        = t_op'(i_in_item.operation);
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;
    assign full      = r_occ == OCC_W'(CAPACITY);
    assign empty     = r_occ == '0;
    assign list_done = (r_cnt + OCC_W'(1)) == r_occ;

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry prev_q;
        logic   prev_after;
        t_entry next_q;

        if (g == 0) begin : g_first
            assign prev_q     = cell_q[0];
            assign prev_after = 1'b1;
        end else begin : g_mid
            assign prev_q     = cell_q[g-1];
            assign prev_after = cell_after[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign next_q = cell_q[g];
        end else begin : g_inner
            assign next_q = cell_q[g+1];
        end

        tcpq_cell #(
            .IDX   (g),
            .OCC_W (OCC_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_occ        (r_occ),
            .i_prev       (prev_q),
            .i_prev_after (prev_after),
            .i_next       (next_q),
            .i_head       (cell_q[0]),
            .o_entry      (cell_q[g]),
            .o_after      (cell_after[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && op == OP_LIST && !empty) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free && list_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath control and results
    always_comb begin
        o_in_ready         = 1'b0;
        cell_ctl.cmd       = CELL_HOLD;
        cell_ctl.new_entry = '{id: i_in_item.entry_id, cls: i_in_item.entry_class};
        n_occ              = r_occ;
        n_cnt              = r_cnt;
        load_out           = 1'b0;
        n_out              = '0;
        n_out.last         = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                n_cnt      = '0;
                if (in_accept) begin
                    case (op)
                        OP_ENQ: begin
                            load_out = 1'b1;
                            if (i_in_item.entry_class == CLS_INVALID) begin
                                n_out.status = ST_INVALID;
                            end else if (full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_out.status = ST_ENQUEUED;
                                cell_ctl.cmd = CELL_INSERT;
                                n_occ        = r_occ + OCC_W'(1);
                            end
                        end
                        OP_SERVE: begin
                            load_out = 1'b1;
                            if (empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_out.status    = ST_ENTRY;
                                n_out.out_id    = cell_q[0].id;
                                n_out.out_class = cell_q[0].cls;
                                cell_ctl.cmd    = CELL_SHIFT;
                                n_occ           = r_occ - OCC_W'(1);
                            end
                        end
                        OP_LIST: begin
                            if (empty) begin
                                load_out     = 1'b1;
                                n_out.status = ST_EMPTY;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    n_out.status    = ST_ENTRY;
                    n_out.out_id    = cell_q[0].id;
                    n_out.out_class = cell_q[0].cls;
                    n_out.last      = list_done;
                    cell_ctl.cmd    = CELL_ROTATE;
                    n_cnt           = r_cnt + OCC_W'(1);
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // fill level never passes the capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    // a list walk only runs over occupied cells
    a_list_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LIST |-> (r_occ != '0) && (r_cnt < r_occ))
        else $error("list walk out of range");

    // a rejected enqueue leaves the fill level alone
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && op == OP_ENQ && full) |=> r_occ == $past(r_occ))
        else $error("full enqueue changed occupancy");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-class priority queue. A directed table
// covers empty, invalid-class and ordering cases, then weighted random traffic
// fills, lists and drains the queue. Every accepted output transaction is checked field
// by field against an in-bench ordered-store predictor, or a hand-typed status for chk rows.
// ----------------------------------------------------------------------------
module tb;
    import tcpq_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    // one row of the directed table: chk marks a hand-typed expected status
    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
        logic             chk;
        t_status          st;
    } t_stim_row;

    localparam int N_ROWS = 23;
    localparam t_stim_row DIR_ROWS [N_ROWS] = '{
        '{OP_SERVE, 16'h0000, 2'd0, 1'b1, ST_EMPTY},
        '{OP_LIST,  16'h0000, 2'd0, 1'b1, ST_EMPTY},
        '{OP_ENQ,   16'hFFFF, 2'd3, 1'b1, ST_INVALID},
        '{OP_NOP,   16'hFFFF, 2'd3, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b1, ST_EMPTY},
        '{OP_ENQ,   16'h0000, 2'd2, 1'b1, ST_ENQUEUED},
        '{OP_ENQ,   16'hFFFF, 2'd0, 1'b1, ST_ENQUEUED},
        '{OP_ENQ,   16'h1234, 2'd1, 1'b1, ST_ENQUEUED},
        '{OP_ENQ,   16'hABCD, 2'd2, 1'b1, ST_ENQUEUED},
        '{OP_ENQ,   16'h5555, 2'd0, 1'b1, ST_ENQUEUED},
        '{OP_ENQ,   16'hAAAA, 2'd1, 1'b1, ST_ENQUEUED},
        '{OP_LIST,  16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_NOP,   16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'hFFFF, 2'd3, 1'b0, ST_ENTRY},
        '{OP_ENQ,   16'h0001, 2'd3, 1'b1, ST_INVALID},
        '{OP_LIST,  16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b0, ST_ENTRY},
        '{OP_SERVE, 16'h0000, 2'd0, 1'b1, ST_EMPTY},
        '{OP_LIST,  16'hFFFF, 2'd2, 1'b1, ST_EMPTY}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // side info travelling with the offered transaction
    logic      item_chk;
    t_status   item_status;

    // predictor state: ordered store and fill count
    logic [ID_W-1:0]  model_ids [CAPACITY];
    logic [CLS_W-1:0] model_cls [CAPACITY];
    int               model_fill;

    t_out_item pending_results [$];
    int        errors;
    bit        quiet;
    bit        long_hold_req;

    three_class_priority_queue #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_out_item make_result(t_status st, logic [ID_W-1:0] id,
                                              logic [CLS_W-1:0] cls, logic last);
        t_out_item r;
        r.status    = st;
        r.out_id    = id;
        r.out_class = cls;
        r.last      = last;
        return r;
    endfunction

    // ordered-store predictor: results of one accepted transaction
    task automatic queue_model_step(t_in_item it, ref t_out_item res[$]);
        int pos;
        int k;
        res.delete();
        case (t_op'(it.operation))
            OP_ENQ: begin
                if (it.entry_class == CLS_INVALID) begin
                    res.push_back(make_result(ST_INVALID, '0, '0, 1'b1));
                end else if (model_fill >= CAPACITY) begin
                    res.push_back(make_result(ST_FULL, '0, '0, 1'b1));
                end else begin
                    // goes behind every entry of its own class or a lower-numbered one
                    pos = 0;
                    while (pos < model_fill && model_cls[pos] <= it.entry_class)
                        pos++;
                    for (k = model_fill; k > pos; k--) begin
                        model_ids[k] = model_ids[k-1];
                        model_cls[k] = model_cls[k-1];
                    end
                    model_ids[pos] = it.entry_id;
                    model_cls[pos] = it.entry_class;
                    model_fill++;
                    res.push_back(make_result(ST_ENQUEUED, '0, '0, 1'b1));
                end
            end
            OP_SERVE: begin
                if (model_fill == 0) begin
                    res.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    res.push_back(make_result(ST_ENTRY, model_ids[0], model_cls[0], 1'b1));
                    for (k = 1; k < model_fill; k++) begin
                        model_ids[k-1] = model_ids[k];
                        model_cls[k-1] = model_cls[k];
                    end
                    model_fill--;
                end
            end
            OP_LIST: begin
                if (model_fill == 0) begin
                    res.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (k = 0; k < model_fill; k++)
                        res.push_back(make_result(ST_ENTRY, model_ids[k], model_cls[k],
                                                  k == model_fill - 1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic cmp_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item step_res [$];
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_item);
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("status", ID_W'(want.status), ID_W'(o_out_item.status));
                    cmp_field("out_id", want.out_id, o_out_item.out_id);
                    cmp_field("out_class", ID_W'(want.out_class),
                              ID_W'(o_out_item.out_class));
                    cmp_field("last", ID_W'(want.last), ID_W'(o_out_item.last));
                end
            end
            if (i_in_valid && o_in_ready) begin
                queue_model_step(i_in_item, step_res);
                if (item_chk)
                    pending_results.push_back(make_result(item_status, '0, '0, 1'b1));
                else
                    foreach (step_res[k]) pending_results.push_back(step_res[k]);
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // offer one transaction and hold it until accepted
    task automatic drive_txn(t_in_item it, logic chk, t_status st);
        i_in_valid  <= 1'b1;
        i_in_item   <= it;
        item_chk    <= chk;
        item_status <= st;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(int w_enq, int w_srv, int w_lst);
        t_in_item it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < w_enq)
            it.operation = OP_ENQ;
        else if (roll < w_enq + w_srv)
            it.operation = OP_SERVE;
        else if (roll < w_enq + w_srv + w_lst)
            it.operation = OP_LIST;
        else
            it.operation = OP_NOP;
        it.entry_id    = 16'($urandom);
        it.entry_class = ($urandom_range(0, 9) == 0) ? CLS_INVALID
                                                     : 2'($urandom_range(0, 2));
        return it;
    endfunction

    // weighted random traffic; no-ops do not count toward n
    task automatic run_phase(int n, int w_enq, int w_srv, int w_lst);
        t_in_item it;
        int counted;
        counted = 0;
        while (counted < n) begin
            it = make_item(w_enq, w_srv, w_lst);
            drive_txn(it, 1'b0, ST_ENTRY);
            if (it.operation != OP_NOP) counted++;
            idle_gap();
        end
    endtask

    // reset, stimulus and end of run
    initial begin : stimulus
        t_in_item it;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_ready   = 1'b0;
        item_chk      = 1'b0;
        item_status   = ST_ENTRY;
        model_fill    = 0;
        errors        = 0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            it.operation   = DIR_ROWS[r].op;
            it.entry_id    = DIR_ROWS[r].id;
            it.entry_class = DIR_ROWS[r].cls;
            drive_txn(it, DIR_ROWS[r].chk, DIR_ROWS[r].st);
            idle_gap();
        end

        // mixed traffic
        run_phase(50, 40, 30, 20);
        // fill to capacity behind a long output stall
        long_hold_req = 1'b1;
        run_phase(65, 85, 5, 5);
        // sender pause until every result is back
        wait_drained();
        // drain toward empty
        run_phase(55, 10, 70, 15);
        // closing stretch without idling
        quiet = 1'b1;
        run_phase(50, 40, 30, 20);

        wait_drained();
        repeat (2 * CAPACITY + 16) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
